// File: rtl/mdm_pkg.sv
package mdm_pkg;

   localparam int NUM_LANES       = 5;
   localparam int THRESHOLD_BITS  = 14;
   localparam int COUNT_BITS      = 3;
   localparam int MAX_SAMPLE_BITS = 16;
   localparam int THR_PAD_BITS    = MAX_SAMPLE_BITS - THRESHOLD_BITS;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = THRESHOLD_BITS;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET      = THRESHOLD_BITS'(8192);
   localparam logic [COUNT_BITS-1:0]     REQUIRED_COUNT_RESET = COUNT_BITS'(2);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD      = 2'd0,
      CSR_REQUIRED_COUNT = 2'd1,
      CSR_EXCLUSIVE_MODE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic first;
      logic last;
   } lane_ctrl_type;

endpackage

// File: rtl/mdm_req_if.sv
interface mdm_req_if #(
   parameter int SAMPLE_BITS = 14
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_a;
   logic [SAMPLE_BITS-1:0] sample_b;
   logic [SAMPLE_BITS-1:0] sample_c;
   logic [SAMPLE_BITS-1:0] sample_d;
   logic [SAMPLE_BITS-1:0] sample_e;
   logic                   first_of_waveform;
   logic                   last_of_event;

   modport source (
      output valid, sample_a, sample_b, sample_c, sample_d, sample_e,
             first_of_waveform, last_of_event,
      input  ready
   );
   modport sink (
      input  valid, sample_a, sample_b, sample_c, sample_d, sample_e,
             first_of_waveform, last_of_event,
      output ready
   );
endinterface

// File: rtl/mdm_rsp_if.sv
interface mdm_rsp_if;
   logic       valid;
   logic       ready;
   logic       pass;
   logic [2:0] hit_count;
   logic [4:0] hit_mask;

   modport source (
      output valid, pass, hit_count, hit_mask,
      input  ready
   );
   modport sink (
      input  valid, pass, hit_count, hit_mask,
      output ready
   );
endinterface

// File: rtl/multichannel_discriminator_majority_unit.sv
// Result: a request marked last of event shows its result in the cycle after acceptance.
// Throughput: one request per cycle while no result waits unread; the five lanes and the
// count/compare stage feed the result register directly, and it frees while it is taken.
// Reset: synchronous, active high; clears armed and hit flags, the result valid,
// and loads threshold 8192, required count 2, exclusive mode off.
module multichannel_discriminator_majority_unit
   import mdm_pkg::*;
#(
   parameter int SAMPLE_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   mdm_req_if.sink                   req,
   mdm_rsp_if.source                 rsp,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [THRESHOLD_BITS-1:0]  threshold_ff;
   logic [COUNT_BITS-1:0]      required_count_ff;
   logic                       exclusive_mode_ff;
   logic [MAX_SAMPLE_BITS-1:0] thr_wide;
   logic [SAMPLE_BITS-1:0]     thr;
   logic [SAMPLE_BITS-1:0]     samples [NUM_LANES];
   logic [NUM_LANES-1:0]       hits;
   logic                       accept;
   logic                       out_valid;
   lane_ctrl_type              ctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff      <= THRESHOLD_RESET;
         required_count_ff <= REQUIRED_COUNT_RESET;
         exclusive_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_THRESHOLD:      threshold_ff      <= csr_data;
            CSR_REQUIRED_COUNT: required_count_ff <= csr_data[COUNT_BITS-1:0];
            CSR_EXCLUSIVE_MODE: exclusive_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // compare on the low sample bits of the threshold
   assign thr_wide = {{THR_PAD_BITS{1'b0}}, threshold_ff};
   assign thr      = thr_wide[SAMPLE_BITS-1:0];

   assign req.ready = ~out_valid | rsp.ready;
   assign accept    = req.valid & req.ready;

   assign ctrl.accept = accept;
   assign ctrl.first  = req.first_of_waveform;
   assign ctrl.last   = req.last_of_event;

   assign samples[0] = req.sample_a;
   assign samples[1] = req.sample_b;
   assign samples[2] = req.sample_c;
   assign samples[3] = req.sample_d;
   assign samples[4] = req.sample_e;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      mdm_lane #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .sample(samples[g]),
         .thr   (thr),
         .hit   (hits[g])
      );
   end

   mdm_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .take          (accept & req.last_of_event),
      .hits          (hits),
      .required_count(required_count_ff),
      .exclusive_mode(exclusive_mode_ff),
      .out_ready     (rsp.ready),
      .out_valid     (out_valid),
      .out_pass      (rsp.pass),
      .out_count     (rsp.hit_count),
      .out_mask      (rsp.hit_mask)
   );

   assign rsp.valid = out_valid;

endmodule

// File: rtl/mdm_lane.sv
module mdm_lane
   import mdm_pkg::*;
#(
   parameter int SAMPLE_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lane_ctrl_type          ctrl,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [SAMPLE_BITS-1:0] thr,
   output logic                   hit
);

   logic armed_ff, armed_in;
   logic hit_ff, hit_in;
   logic below, above;
   logic new_hit;

   assign below = sample < thr;
   assign above = sample > thr;

   always_comb begin
      armed_in = armed_ff;
      new_hit  = 1'b0;
      if (ctrl.first) begin
         armed_in = below;
      end else if (!armed_ff) begin
         if (below) begin
            armed_in = 1'b1;
            new_hit  = 1'b1;
         end
      end else if (above) begin
         armed_in = 1'b0;
      end
   end

   // hit seen so far in this event, including the current request
   assign hit = hit_ff | new_hit;

   // drop the hit once the event result is taken
   assign hit_in = ctrl.last ? 1'b0 : hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else if (ctrl.accept) begin
         armed_ff <= armed_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

// File: rtl/mdm_merge.sv
module mdm_merge
   import mdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [NUM_LANES-1:0]  hits,
   input  logic [COUNT_BITS-1:0] required_count,
   input  logic                  exclusive_mode,
   input  logic                  out_ready,
   output logic                  out_valid,
   output logic                  out_pass,
   output logic [COUNT_BITS-1:0] out_count,
   output logic [NUM_LANES-1:0]  out_mask
);

   logic                  valid_ff, valid_in;
   logic                  pass_ff, pass_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [NUM_LANES-1:0]  mask_ff;

   always_comb begin
      count_in = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         count_in = count_in + COUNT_BITS'(hits[i]);
      end
      pass_in = exclusive_mode ? (count_in == required_count)
                               : (count_in >= required_count);
   end

   assign valid_in = take | (valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pass_ff  <= pass_in;
         count_ff <= count_in;
         mask_ff  <= hits;
      end
   end

   assign out_valid = valid_ff;
   assign out_pass  = pass_ff;
   assign out_count = count_ff;
   assign out_mask  = mask_ff;

   a_count_matches_mask: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (32'(count_ff) == $countones(mask_ff)))
      else $error("hit count disagrees with hit mask");

   a_valid_from_take: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(take))
      else $error("result appeared without an event end");

   a_exclusive_pass: assert property (@(posedge clock) disable iff (reset)
      (take && exclusive_mode && pass_in) |=> (count_ff == $past(required_count)))
      else $error("exclusive pass with wrong count");

endmodule

// File: dv/tb.sv
module tb;
   import mdm_pkg::*;

   localparam int SAMPLE_BITS   = 14;
   localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 80;
   localparam int NUM_PHASES    = 11;
   localparam int HOLD_PHASE    = 6;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] sample;
      logic                                  first;
      logic                                  last;
   } tick_type;

   typedef struct packed {
      logic                  pass;
      logic [COUNT_BITS-1:0] hit_count;
      logic [NUM_LANES-1:0]  hit_mask;
   } verdict_type;

   typedef enum int {LVL_ABOVE, LVL_BELOW, LVL_EQUAL} level_type;
   typedef enum int {LANE_QUIET, LANE_PULSE, LANE_NOISE, LANE_HOVER} lane_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   mdm_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   mdm_rsp_if                              rsp_bus ();

   multichannel_discriminator_majority_unit #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   tick_type    tick_q[$];
   verdict_type verdict_q[$];
   int          errors = 0;
   int          drv_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          hold_req = 0;

   // discriminator state and registers as the block should hold them
   logic [THRESHOLD_BITS-1:0] mdl_threshold;
   logic [COUNT_BITS-1:0]     mdl_required;
   logic                      mdl_exclusive;
   logic [NUM_LANES-1:0]      mdl_armed;
   logic [NUM_LANES-1:0]      mdl_hits;

   task automatic discriminate(input tick_type t);
      logic [SAMPLE_BITS-1:0] s;
      logic [SAMPLE_BITS-1:0] thr;
      int                     cnt;
      verdict_type            v;
      thr = mdl_threshold[SAMPLE_BITS-1:0];
      cnt = 0;
      for (int lane = 0; lane < NUM_LANES; lane++) begin
         s = t.sample[lane];
         if (t.first) begin
            mdl_armed[lane] = (s < thr);
         end else if (!mdl_armed[lane]) begin
            if (s < thr) begin
               mdl_armed[lane] = 1'b1;
               mdl_hits[lane]  = 1'b1;
            end
         end else if (s > thr) begin
            mdl_armed[lane] = 1'b0;
         end
      end
      if (t.last) begin
         for (int lane = 0; lane < NUM_LANES; lane++)
            cnt += mdl_hits[lane];
         v.pass      = (cnt >= mdl_required) && (!mdl_exclusive || cnt == mdl_required);
         v.hit_count = COUNT_BITS'(cnt);
         v.hit_mask  = mdl_hits;
         verdict_q = {verdict_q, v};
         mdl_hits = '0;
      end
   endtask

   // request driver
   int drv_gap;
   always @(posedge clock) begin
      tick_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         drv_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            tick_q.delete(0);
         if (req_bus.valid && !req_bus.ready) begin
            // hold the offered request
         end else if (drv_gap != 0) begin
            drv_gap--;
            req_bus.valid <= 1'b0;
         end else if (tick_q.size() != 0 && drv_idle_pct != 0 &&
                      $urandom_range(0, 99) < drv_idle_pct) begin
            drv_gap = $urandom_range(1, 8) - 1;
            req_bus.valid <= 1'b0;
         end else if (tick_q.size() != 0) begin
            nxt = tick_q[0];
            req_bus.valid             <= 1'b1;
            req_bus.sample_a          <= nxt.sample[0];
            req_bus.sample_b          <= nxt.sample[1];
            req_bus.sample_c          <= nxt.sample[2];
            req_bus.sample_d          <= nxt.sample[3];
            req_bus.sample_e          <= nxt.sample[4];
            req_bus.first_of_waveform <= nxt.first;
            req_bus.last_of_event     <= nxt.last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver with random stalls and a long hold-off on demand
   int rsp_stall;
   int hold_left;
   int hold_seen;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
         hold_left = 0;
         hold_seen = 0;
      end else if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_stall = $urandom_range(1, 8) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: track registers, predict on each request, check each result
   always @(posedge clock) begin
      tick_type    seen;
      verdict_type want;
      if (reset) begin
         mdl_threshold = THRESHOLD_RESET;
         mdl_required  = REQUIRED_COUNT_RESET;
         mdl_exclusive = 1'b0;
         mdl_armed     = '0;
         mdl_hits      = '0;
         verdict_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_THRESHOLD:      mdl_threshold = csr_data[THRESHOLD_BITS-1:0];
               CSR_REQUIRED_COUNT: mdl_required  = csr_data[COUNT_BITS-1:0];
               CSR_EXCLUSIVE_MODE: mdl_exclusive = csr_data[0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.sample[0] = req_bus.sample_a;
            seen.sample[1] = req_bus.sample_b;
            seen.sample[2] = req_bus.sample_c;
            seen.sample[3] = req_bus.sample_d;
            seen.sample[4] = req_bus.sample_e;
            seen.first     = req_bus.first_of_waveform;
            seen.last      = req_bus.last_of_event;
            discriminate(seen);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected result: pass %0d hit_count %0d hit_mask %b",
                      rsp_bus.pass, rsp_bus.hit_count, rsp_bus.hit_mask);
               errors++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_bus.pass !== want.pass) begin
                  $error("pass: expected %0d, actual %0d", want.pass, rsp_bus.pass);
                  errors++;
               end
               if (rsp_bus.hit_count !== want.hit_count) begin
                  $error("hit_count: expected %0d, actual %0d",
                         want.hit_count, rsp_bus.hit_count);
                  errors++;
               end
               if (rsp_bus.hit_mask !== want.hit_mask) begin
                  $error("hit_mask: expected %b, actual %b", want.hit_mask, rsp_bus.hit_mask);
                  errors++;
               end
            end
         end
      end
   end

   task automatic push_tick(input int a, input int b, input int c, input int d, input int e,
                            input bit first, input bit last);
      tick_type t;
      t.sample[0] = SAMPLE_BITS'(a);
      t.sample[1] = SAMPLE_BITS'(b);
      t.sample[2] = SAMPLE_BITS'(c);
      t.sample[3] = SAMPLE_BITS'(d);
      t.sample[4] = SAMPLE_BITS'(e);
      t.first     = first;
      t.last      = last;
      tick_q = {tick_q, t};
   endtask

   function automatic logic [SAMPLE_BITS-1:0] level(input int thr, input level_type k);
      int v;
      case (k)
         LVL_ABOVE: v = ($urandom_range(0, 7) == 0) ? SAMPLE_MAX
                                                    : thr + int'($urandom_range(1, 2000));
         LVL_BELOW: v = ($urandom_range(0, 7) == 0) ? 0 : thr - int'($urandom_range(1, 2000));
         default:   v = thr;
      endcase
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < 0) v = 0;
      return SAMPLE_BITS'(v);
   endfunction

   // one event of one or more board records; drop the record markers when broken
   task automatic queue_event(input int thr, input bit broken);
      int            n_rec;
      int            len;
      lane_mode_type mode[NUM_LANES];
      int            p_at[NUM_LANES];
      int            p_len[NUM_LANES];
      tick_type      t;
      n_rec = $urandom_range(1, 3);
      for (int r = 0; r < n_rec; r++) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 6);
         for (int lane = 0; lane < NUM_LANES; lane++) begin
            mode[lane]  = lane_mode_type'($urandom_range(0, 3));
            p_at[lane]  = $urandom_range(0, len - 1);
            p_len[lane] = $urandom_range(1, 4);
         end
         for (int i = 0; i < len; i++) begin
            t.first = (i == 0) && !broken;
            t.last  = (r == n_rec - 1) && (i == len - 1);
            for (int lane = 0; lane < NUM_LANES; lane++) begin
               case (mode[lane])
                  LANE_QUIET: t.sample[lane] = level(thr, LVL_ABOVE);
                  LANE_PULSE: t.sample[lane] =
                     (i >= p_at[lane] && i < p_at[lane] + p_len[lane]) ?
                     level(thr, LVL_BELOW) : level(thr, LVL_ABOVE);
                  LANE_NOISE: t.sample[lane] = SAMPLE_BITS'($urandom);
                  default:    t.sample[lane] = level(thr, level_type'($urandom_range(0, 2)));
               endcase
            end
            tick_q = {tick_q, t};
         end
      end
   endtask

   task automatic queue_noise();
      tick_type t;
      int       n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         for (int lane = 0; lane < NUM_LANES; lane++)
            t.sample[lane] = SAMPLE_BITS'($urandom);
         t.first = ($urandom_range(0, 3) == 0);
         t.last  = ($urandom_range(0, 3) == 0);
         tick_q = {tick_q, t};
      end
   endtask

   task automatic program_regs(input int thr, input int cnt, input int excl);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_THRESHOLD;
      csr_data         <= CSR_DATA_BITS'(thr);
      @(posedge clock);
      csr_index        <= CSR_REQUIRED_COUNT;
      csr_data         <= CSR_DATA_BITS'(cnt);
      @(posedge clock);
      csr_index        <= CSR_EXCLUSIVE_MODE;
      csr_data         <= CSR_DATA_BITS'(excl);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // wait until every request is taken and every result is in, then let the block settle
   task automatic drain_all();
      while (tick_q.size() != 0 || req_bus.valid)
         @(posedge clock);
      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int thr_tab[NUM_PHASES]  = '{8192, 0, 16383, 1000, 12000, 5000, 8192, 300, 15000, 0, 8191};
      int cnt_tab[NUM_PHASES]  = '{2, 0, 5, 0, 7, 6, 3, 1, 4, 0, 2};
      int excl_tab[NUM_PHASES] = '{1, 0, 0, 1, 0, 1, 0, 1, 0, 0, 0};
      int thr;
      int pick;
      req_bus.valid             = 1'b0;
      req_bus.sample_a          = '0;
      req_bus.sample_b          = '0;
      req_bus.sample_c          = '0;
      req_bus.sample_d          = '0;
      req_bus.sample_e          = '0;
      req_bus.first_of_waveform = 1'b0;
      req_bus.last_of_event     = 1'b0;
      rsp_bus.ready             = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, threshold at reset value 8192
      drv_idle_pct = 15;
      rsp_idle_pct = 15;
      push_tick(0, 16383, 8192, 8191, 8193, 1, 0);
      push_tick(16383, 16383, 16383, 16383, 16383, 0, 0);
      push_tick(0, 1, 8191, 0, 8192, 0, 0);
      push_tick(8192, 8192, 8192, 8192, 8192, 0, 0);
      push_tick(16383, 16383, 16383, 16383, 16383, 0, 1);
      push_tick(0, 0, 0, 0, 0, 0, 0);
      push_tick(0, 0, 0, 0, 0, 0, 1);
      // still armed from the last event: no new hits
      push_tick(0, 0, 0, 0, 0, 0, 1);
      // first and last together only arm
      push_tick(0, 0, 0, 0, 0, 1, 1);
      push_tick(16383, 16383, 16383, 16383, 16383, 1, 0);
      push_tick(0, 16383, 16383, 16383, 16383, 0, 0);
      push_tick(16383, 0, 16383, 16383, 16383, 0, 1);
      push_tick(16383, 16383, 16383, 16383, 16383, 0, 0);
      push_tick(100, 9000, 8192, 16383, 12345, 0, 0);
      push_tick(0, 0, 0, 0, 0, 1, 1);
      push_tick(10922, 5461, 16383, 0, 8191, 0, 0);
      push_tick(5461, 10922, 0, 16383, 8193, 0, 1);
      drain_all();

      for (int p = 0; p < NUM_PHASES; p++) begin
         thr = (p == 9) ? $urandom_range(0, SAMPLE_MAX) : thr_tab[p];
         if (p == 9)
            program_regs(thr, $urandom_range(0, 7), $urandom_range(0, 1));
         else
            program_regs(thr, cnt_tab[p], excl_tab[p]);
         drv_idle_pct = (p == 2 || p == HOLD_PHASE || p == NUM_PHASES - 1) ? 0 : 15;
         rsp_idle_pct = (p == 2 || p == NUM_PHASES - 1) ? 0 : 15;
         while (tick_q.size() < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               queue_noise();
            else
               queue_event(thr, pick == 1);
         end
         // stall the results while requests keep coming
         if (p == HOLD_PHASE)
            hold_req++;
         drain_all();
      end

      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
